@@ hdl/stbs_pkg.sv @@
// shared types and constants for the sorted table bound search unit
// no dependencies; compiled first

package stbs_pkg;

  // fixed field widths of the channels
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned CNT_W   = 11;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_UPPER = 2'd1,
    OP_LOWER = 2'd2,
    OP_EXACT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

endpackage

@@ hdl/stbs_ifs.sv @@
// channel interfaces: request, result and entry-count write channels
// depends on stbs_pkg

interface stbs_in_if;
  import stbs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPC_W-1:0]           opcode;
  logic [IDX_W-1:0]           entry_index;
  logic signed [KEY_IN_W-1:0] key;
  logic                       inclusive;
  modport source (output valid, opcode, entry_index, key, inclusive, input ready);
  modport sink (input valid, opcode, entry_index, key, inclusive, output ready);
endinterface

interface stbs_out_if;
  import stbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

interface stbs_cfg_if;
  import stbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hdl/stbs_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies

module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/sorted_table_bound_search_unit.sv @@
// top level of the sorted table bound search unit: key table, search sequencer, result register
// depends on stbs_pkg, stbs_ifs (channel interfaces) and stbs_ram

// Holds a table of TABLE_DEPTH signed keys, loaded one entry per load transaction and
// expected to be sorted non-decreasing over the first entries_in_use entries (written on
// the cfg channel, saturated to TABLE_DEPTH). Query transactions run a binary search with
// mid = left + (right - left) / 2: upper bound returns the first index whose key is above
// the target (at or above with inclusive), lower bound the last index below it (at or
// below with inclusive), exact the index of the first probe that equals the target;
// a query with no answer returns found = 0 and position = 0. Keys are compared as signed
// integers, so float keys must arrive already mapped to an order-preserving integer form.
// A load yields no result. A query issues the first read on accept, probes the table at
// most clog2(TABLE_DEPTH) + 1 times (so 11 for 1024 entries) and posts the result once
// the output register is free; the single table read port with its registered read data
// sets the probe rate, since each probe address depends on the previous compare.
// One query is in flight at a time; the next transaction is taken while a finished result
// still waits in the output register. The table is not cleared by reset.

module sorted_table_bound_search_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  stbs_in_if.sink    in_ch,
  stbs_out_if.source out_ch,
  stbs_cfg_if.sink   cfg_ch
);

  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);      // table address
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);  // entry count
  localparam int unsigned SW = CW + 1;                   // signed search bounds

  localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // control and search state
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic                 incl_r, incl_nxt;
  logic [KEY_WIDTH-1:0] target_r, target_nxt;
  logic signed [SW-1:0] left_r, left_nxt;
  logic signed [SW-1:0] right_r, right_nxt;
  logic signed [SW-1:0] mid_r, mid_nxt;
  logic                 hit_r, hit_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  // table port
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_key;

  logic                 in_acc;
  logic                 is_query;
  logic [KEY_WIDTH-1:0] key_enc;
  logic signed [SW-1:0] cnt_s;
  logic signed [SW-1:0] right0;
  logic signed [SW-1:0] mid0;
  logic                 slot_free;

  // probe compare and candidate next probes
  logic                 k_eq, k_lt, k_gt;
  logic                 go_left;
  logic                 hit_now;
  logic signed [SW-1:0] mid_m1, mid_p1;
  logic signed [SW-1:0] mid_lo, mid_hi;
  logic signed [SW-1:0] l_n, r_n, m_n;
  logic                 search_done;

  // result selection
  logic                 res_found;
  logic signed [SW-1:0] res_pos;

  // handshakes
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_query     = (op_t'(in_ch.opcode) != OP_LOAD);
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  // keys live in offset form (sign bit flipped) so an unsigned compare orders them
  assign key_enc = KEY_WIDTH'($unsigned(in_ch.key)) ^ KEY_SIGN;

  // search window for a new query: left = 0, right = n - 1
  assign cnt_s  = $signed({1'b0, cnt_r});
  assign right0 = cnt_s - SW'(1);
  assign mid0   = right0 >>> 1;

  // loads only happen in idle, probe reads on query accept and during a search, so no port conflict;
  // a load followed at once by a query reading that entry sees the new key
  assign wr_en = in_acc && !is_query &&
                 (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_ch.entry_index)),
    .wr_data (key_enc),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  // compare the key just read against the target
  assign k_eq = (rd_key == target_r);
  assign k_lt = (rd_key < target_r);
  assign k_gt = !k_eq && !k_lt;

  always_comb begin
    go_left = 1'b0;
    hit_now = 1'b0;
    case (op_r)
      OP_UPPER: go_left = k_gt || (incl_r && k_eq);
      OP_LOWER: go_left = !(k_lt || (incl_r && k_eq));
      OP_EXACT: begin
        go_left = k_gt;
        hit_now = k_eq;
      end
      default: go_left = 1'b0;
    endcase
  end

  // both possible next probes are formed in parallel with the compare
  assign mid_m1 = mid_r - SW'(1);
  assign mid_p1 = mid_r + SW'(1);
  assign mid_lo = left_r + ((mid_m1 - left_r) >>> 1);
  assign mid_hi = mid_p1 + ((right_r - mid_p1) >>> 1);

  assign l_n = go_left ? left_r : mid_p1;
  assign r_n = go_left ? mid_m1 : right_r;
  assign m_n = go_left ? mid_lo : mid_hi;

  assign search_done = hit_now || (l_n > r_n);

  // read address: first probe on accept, else the next probe chosen by this compare
  assign rd_addr = (state_r == ST_IDLE) ? mid0[AW-1:0] : m_n[AW-1:0];

  // final answer from the closed window
  always_comb begin
    res_found = 1'b0;
    res_pos   = '0;
    case (op_r)
      OP_UPPER: begin
        res_found = (left_r < cnt_s);
        res_pos   = left_r;
      end
      OP_LOWER: begin
        res_found = (right_r >= 0);
        res_pos   = right_r;
      end
      OP_EXACT: begin
        res_found = hit_r;
        res_pos   = mid_r;
      end
      default: res_found = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          // empty table skips straight to a not-found answer
          state_nxt = (cnt_r == '0) ? ST_RESULT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    incl_nxt      = incl_r;
    target_nxt    = target_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    mid_nxt       = mid_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;

    // entry count saturates at the table depth
    if (32'(cfg_ch.data) > 32'(TABLE_DEPTH)) begin
      cnt_nxt = CW'(TABLE_DEPTH);
    end else begin
      cnt_nxt = CW'(cfg_ch.data);
    end
    if (!(cfg_ch.valid && cfg_ch.ready)) begin
      cnt_nxt = cnt_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          op_nxt     = op_t'(in_ch.opcode);
          incl_nxt   = in_ch.inclusive;
          target_nxt = key_enc;
          left_nxt   = '0;
          right_nxt  = right0;
          mid_nxt    = mid0;
          hit_nxt    = 1'b0;
        end
      end
      ST_SEARCH: begin
        hit_nxt = hit_now;
        if (!hit_now) begin
          left_nxt  = l_n;
          right_nxt = r_n;
          mid_nxt   = m_n;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found;
          out_pos_nxt   = res_found ? POS_W'($unsigned(res_pos)) : '0;
        end
      end
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    incl_r      <= incl_nxt;
    target_r    <= target_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    mid_r       <= mid_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

endmodule

@@ hdl/stbs_checker.sv @@
// port-level checks for the sorted table bound search unit, bound to the top level
// depends on stbs_pkg and sorted_table_bound_search_unit

module stbs_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              in_opcode,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_found,
  input logic [9:0]              out_position
);

  import stbs_pkg::*;

  // a result stalled by the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a query transaction blocks the request channel for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_LOAD) |=> !in_ready)
    else $error("request taken during a search");

  // a new result only appears once a query has left idle, never straight out of idle
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a search");

  // not-found answers carry position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("nonzero position on a miss");

endmodule

bind sorted_table_bound_search_unit stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_opcode    (in_ch.opcode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_position (out_ch.position)
);
